@@ rtl/core/polynomial_term_sum_product_assert.svh @@
// Assertion macros shared by the polynomial term engine RTL.
// Needs nothing else; files that assert include it inside their module body.
`ifndef POLYNOMIAL_TERM_SUM_PRODUCT_ASSERT_SVH
`define POLYNOMIAL_TERM_SUM_PRODUCT_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define PTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pts assertion failed");

// Condition that must never be true outside reset.
`define PTS_NEVER(lbl, clk, rstn, cond) \
  `PTS_ASSERT(lbl, clk, rstn, !(cond))

`endif

@@ rtl/core/pts_pkg.sv @@
// Package of the polynomial term engine: item types, sizes and back-end states.
// Used by every module of the block but pts_ram; depends on nothing.
package pts_pkg;

  localparam int MAX_TERMS    = 32;
  localparam int MAX_EXPONENT = 31;
  localparam int ACC_DEPTH    = 2 * MAX_EXPONENT + 1;
  localparam int ACC_AW       = $clog2(ACC_DEPTH);
  localparam int TERM_AW      = $clog2(MAX_TERMS);
  localparam int CNT_W        = $clog2(MAX_TERMS + 1);
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int TERM_W       = 32 + 5;

  typedef struct packed {
    logic              op;
    logic signed [31:0] coefficient;
    logic [4:0]        exponent;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_coefficient;
    logic [5:0]        result_exponent;
    logic              last_term;
    logic              saturated;
  } result_t;

  typedef enum logic [1:0] {
    KIND_SUM_A,
    KIND_SUM_B,
    KIND_PROD_A,
    KIND_PROD_B
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic signed [31:0] coefficient;
    logic [4:0]        exponent;
    logic              last;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_WR,
    ST_A_RD,
    ST_MUL,
    ST_ADD,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_DONE
  } state_e;

endpackage

@@ rtl/core/pts_ram.sv @@
// Generic simple dual-port RAM with registered read and read enable.
// No dependencies.
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/pts_front.sv @@
// Front end: holds the mode register, accepts items, classifies them and queues them.
// Depends on pts_pkg.
module pts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mode_we_i,
  input  logic              mode_i,
  input  logic              push_i,
  output logic              full_o,
  input  pts_pkg::in_item_t item_i,
  output logic              cmd_valid_o,
  output pts_pkg::cmd_t     cmd_o,
  input  logic              cmd_take_i
);
  import pts_pkg::*;

  logic              mode_q;
  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;
  cmd_t              cmd_new;

  assign full_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  // The mode is captured with each item, so later mode writes do not reach it.
  always_comb begin
    cmd_new.coefficient = item_i.coefficient;
    cmd_new.exponent    = item_i.exponent;
    cmd_new.last        = item_i.last;
    case ({mode_q, item_i.op})
      2'b00:   cmd_new.kind = KIND_SUM_A;
      2'b01:   cmd_new.kind = KIND_SUM_B;
      2'b10:   cmd_new.kind = KIND_PROD_A;
      default: cmd_new.kind = KIND_PROD_B;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (mode_we_i) begin
        mode_q <= mode_i;
      end
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_new;
    end
  end

endmodule

@@ rtl/core/pts_back.sv @@
// Back end: term store, accumulator memory, product sequencer and result emitter.
// Depends on pts_pkg, pts_ram and the assertion header.
module pts_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  pts_pkg::cmd_t     cmd_i,
  output logic              cmd_take_o,
  output logic              empty_o,
  input  logic              pop_i,
  output pts_pkg::result_t  result_o
);
  import pts_pkg::*;
  `include "polynomial_term_sum_product_assert.svh"

  state_e                state_q, state_d;
  logic signed [31:0]    coef_q, coef_d;
  logic [4:0]            exp_q, exp_d;
  logic                  last_q, last_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d, idx_q, idx_d;
  logic [ACC_AW-1:0]     k_q, k_d, ae_q, ae_d;
  logic signed [63:0]    prod_q, prod_d;
  logic                  hit_q, hit_d;
  logic [ACC_DEPTH-1:0]  present_q, present_d;
  logic                  out_valid_q, out_valid_d;
  result_t               out_q, out_d;

  logic                  term_we, term_re;
  logic [TERM_AW-1:0]    term_waddr, term_raddr;
  logic [TERM_W-1:0]     term_wdata, term_rdata;
  logic                  acc_we, acc_re;
  logic [ACC_AW-1:0]     acc_waddr, acc_raddr;
  logic [63:0]           acc_wdata, acc_rdata;

  logic signed [63:0]    acc_old;
  logic signed [31:0]    a_coef;
  logic [4:0]            a_exp;
  logic [ACC_AW-1:0]     sum_exp;
  logic                  store_ok, can_load;
  logic [ACC_DEPTH-1:0]  below_mask;

  pts_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (term_we),
    .waddr_i (term_waddr),
    .wdata_i (term_wdata),
    .re_i    (term_re),
    .raddr_i (term_raddr),
    .rdata_o (term_rdata)
  );

  pts_ram #(.WIDTH(64), .DEPTH(ACC_DEPTH)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // An accumulator whose present bit was clear reads as zero.
  assign acc_old    = hit_q ? $signed(acc_rdata) : 64'sd0;
  assign a_coef     = $signed(term_rdata[31:0]);
  assign a_exp      = term_rdata[TERM_W-1:32];
  assign sum_exp    = ACC_AW'(a_exp) + ACC_AW'(exp_q);
  assign store_ok   = (cnt_q < CNT_W'(MAX_TERMS));
  assign can_load   = !out_valid_q || pop_i;
  assign below_mask = (ACC_DEPTH'(1) << k_q) - ACC_DEPTH'(1);
  assign empty_o    = !out_valid_q;
  assign result_o   = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            KIND_SUM_A: begin
              if (store_ok) state_d = ST_ACC_WR;
              else          state_d = cmd_i.last ? ST_EMIT_RD : ST_IDLE;
            end
            KIND_SUM_B:  state_d = ST_ACC_WR;
            KIND_PROD_B: begin
              if (cnt_q != '0) state_d = ST_A_RD;
              else             state_d = cmd_i.last ? ST_EMIT_RD : ST_IDLE;
            end
            default:     state_d = cmd_i.last ? ST_EMIT_RD : ST_IDLE;
          endcase
        end
      end
      ST_ACC_WR: state_d = last_q ? ST_EMIT_RD : ST_IDLE;
      ST_A_RD:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_ADD;
      ST_ADD: begin
        if (idx_q + 1'b1 == cnt_q) state_d = last_q ? ST_EMIT_RD : ST_IDLE;
        else                       state_d = ST_A_RD;
      end
      ST_EMIT_RD: begin
        if (present_q[k_q]) state_d = ST_EMIT_WR;
        else if (k_q == '0) state_d = ST_DONE;
      end
      ST_EMIT_WR: begin
        if (can_load) state_d = (k_q == '0) ? ST_DONE : ST_EMIT_RD;
      end
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cmd_take_o  = 1'b0;
    coef_d      = coef_q;
    exp_d       = exp_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    k_d         = k_q;
    ae_d        = ae_q;
    prod_d      = prod_q;
    hit_d       = hit_q;
    present_d   = present_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    term_we     = 1'b0;
    term_re     = 1'b0;
    term_waddr  = cnt_q[TERM_AW-1:0];
    term_wdata  = {cmd_i.exponent, cmd_i.coefficient};
    term_raddr  = idx_q[TERM_AW-1:0];
    acc_we      = 1'b0;
    acc_re      = 1'b0;
    acc_waddr   = ae_q;
    acc_wdata   = acc_old + (prod_q >>> 16);
    acc_raddr   = ACC_AW'(cmd_i.exponent);
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          coef_d     = cmd_i.coefficient;
          exp_d      = cmd_i.exponent;
          last_d     = cmd_i.last;
          idx_d      = '0;
          if ((cmd_i.kind == KIND_SUM_A || cmd_i.kind == KIND_PROD_A) && store_ok) begin
            term_we = 1'b1;
            cnt_d   = cnt_q + 1'b1;
          end
          if ((cmd_i.kind == KIND_SUM_A && store_ok) || cmd_i.kind == KIND_SUM_B) begin
            acc_re = 1'b1;
            hit_d  = present_q[ACC_AW'(cmd_i.exponent)];
          end
        end
      end
      ST_ACC_WR: begin
        acc_we                       = 1'b1;
        acc_waddr                    = ACC_AW'(exp_q);
        acc_wdata                    = acc_old + 64'(coef_q);
        present_d[ACC_AW'(exp_q)]    = 1'b1;
      end
      ST_A_RD: begin
        term_re = 1'b1;
      end
      ST_MUL: begin
        prod_d    = a_coef * coef_q;
        acc_re    = 1'b1;
        acc_raddr = sum_exp;
        ae_d      = sum_exp;
        hit_d     = present_q[sum_exp];
      end
      ST_ADD: begin
        acc_we           = 1'b1;
        present_d[ae_q]  = 1'b1;
        idx_d            = idx_q + 1'b1;
      end
      ST_EMIT_RD: begin
        acc_raddr = k_q;
        hit_d     = 1'b1;
        if (present_q[k_q]) begin
          acc_re = 1'b1;
        end else if (k_q != '0) begin
          k_d = k_q - 1'b1;
        end
      end
      ST_EMIT_WR: begin
        if (can_load) begin
          out_valid_d           = 1'b1;
          out_d.result_exponent = 6'(k_q);
          out_d.last_term       = ((present_q & below_mask) == '0);
          if (acc_old > 64'sd2147483647) begin
            out_d.result_coefficient = 32'sh7FFFFFFF;
            out_d.saturated          = 1'b1;
          end else if (acc_old < -64'sd2147483648) begin
            out_d.result_coefficient = 32'sh80000000;
            out_d.saturated          = 1'b1;
          end else begin
            out_d.result_coefficient = acc_old[31:0];
            out_d.saturated          = 1'b0;
          end
          if (k_q != '0) k_d = k_q - 1'b1;
        end
      end
      ST_DONE: begin
        present_d = '0;
        cnt_d     = '0;
        k_d       = ACC_AW'(ACC_DEPTH - 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      k_q         <= ACC_AW'(ACC_DEPTH - 1);
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
    exp_q  <= exp_d;
    last_q <= last_d;
    ae_q   <= ae_d;
    prod_q <= prod_d;
    hit_q  <= hit_d;
    out_q  <= out_d;
  end

  `PTS_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CNT_W'(MAX_TERMS))
  `PTS_ASSERT(a_mul_after_rd, clk_i, rst_ni, state_q == ST_MUL |-> $past(state_q) == ST_A_RD)
  `PTS_ASSERT(a_done_clears, clk_i, rst_ni, state_q == ST_DONE |=> present_q == '0)
  `PTS_ASSERT(a_emit_stable, clk_i, rst_ni, state_q == ST_EMIT_RD |=> $stable(present_q))

endmodule

@@ rtl/core/polynomial_term_sum_product.sv @@
// Top level of the sparse polynomial sum and product engine.
// Depends on pts_pkg, pts_front and pts_back.

// Terms of polynomial A (op 0) and then of polynomial B (op 1) are pushed as items of
// signed Q16.16 coefficient and 5-bit exponent. The mode register selects sum (0) or
// product (1) and is captured with each item when it is accepted. In sum mode every B
// term and at most 32 A terms (further ones are dropped) are added into a 64-bit
// accumulator at their exponent; in product mode A terms are stored (at most 32,
// further ones are dropped) and each B term is multiplied with every stored A term, the
// product shifted right by 16 and added at the summed exponent. An item with last set
// triggers the output: every touched exponent is delivered in descending order,
// saturated to 32 bits with a flag, the lowest one marked as the last term, and all
// state is cleared. Zero sums are still delivered; an empty result gives no items.
// Timing: the front end takes an item whenever its two-entry queue has room. The back
// end reads and writes the accumulator for a sum-mode term, stores a product-mode A
// term on acceptance, and for a product-mode B term reads the store, multiplies and
// accumulates per stored A term. The output pass visits all 63 exponents, skips
// untouched ones, reads each touched one and emits it once the output register is
// free, then clears all state. A result waits in an output register until popped.
module polynomial_term_sum_product (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mode_we_i,
  input  logic              mode_i,
  input  logic              push,
  output logic              full,
  input  pts_pkg::in_item_t item_i,
  output logic              empty,
  input  logic              pop,
  output pts_pkg::result_t  result_o
);
  import pts_pkg::*;

  logic full_w, empty_w;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  // The handshake names are fixed by the interface.
  assign full  = full_w;
  assign empty = empty_w;

  pts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_we_i   (mode_we_i),
    .mode_i      (mode_i),
    .push_i      (push),
    .full_o      (full_w),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  pts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty_o     (empty_w),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule
